[src/rs485_register_access_master_core_macros.svh]
// Assertion macros for the RS485 register access master core.
`ifndef RS485_REGISTER_ACCESS_MASTER_CORE_MACROS_SVH
`define RS485_REGISTER_ACCESS_MASTER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define RSM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rsm check failed");
`define RSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rsm check failed");
`else
`define RSM_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define RSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[src/rsm_pkg.sv]
// Types and constants shared by the RS485 register access master core.
package rsm_pkg;

	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_BYTE  = 2'd1;
	localparam logic [1:0] ACT_TICK  = 2'd2;

	localparam logic KIND_TX     = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [2:0] OUTC_OK       = 3'd0;
	localparam logic [2:0] OUTC_TIMEOUT  = 3'd1;
	localparam logic [2:0] OUTC_NACK     = 3'd2;
	localparam logic [2:0] OUTC_CHECKSUM = 3'd3;
	localparam logic [2:0] OUTC_INVALID  = 3'd4;

	localparam logic [2:0] CFG_START_MARKER  = 3'd0;
	localparam logic [2:0] CFG_CHECKSUM_SEED = 3'd1;
	localparam logic [2:0] CFG_ACK_NIBBLE    = 3'd2;
	localparam logic [2:0] CFG_NACK_NIBBLE   = 3'd3;
	localparam logic [2:0] CFG_READ8_CMD     = 3'd4;
	localparam logic [2:0] CFG_READ16_CMD    = 3'd5;

	localparam logic [2:0] REPLY_SHORT  = 3'd2;
	localparam logic [2:0] REPLY_READ8  = 3'd3;
	localparam logic [2:0] REPLY_READ16 = 3'd4;

	localparam int FRAME_MAX = 6;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  device_address;
		logic [7:0]  command_code;
		logic [7:0]  register_index;
		logic [7:0]  payload_low;
		logic [7:0]  payload_high;
		logic [1:0]  payload_count;
		logic [15:0] wait_limit_ms;
		logic [7:0]  incoming_byte;
	} rsm_req_t;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  transmit_byte;
		logic        frame_end;
		logic [2:0]  outcome;
		logic [15:0] read_value;
	} rsm_rsp_t;

	// everything one accepted item produces, handed to the output stage at once
	typedef struct packed {
		logic                      kind;
		logic [FRAME_MAX-1:0][7:0] bytes;
		logic [2:0]                beats;
		logic [2:0]                outcome;
		logic [15:0]               read_value;
	} rsm_bundle_t;

endpackage

[src/rsm_req_if.sv]
// Request channel interface.
interface rsm_req_if;
	import rsm_pkg::*;
	logic     valid;
	logic     ready;
	rsm_req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/rsm_rsp_if.sv]
// Result channel interface.
interface rsm_rsp_if;
	import rsm_pkg::*;
	logic     valid;
	logic     ready;
	rsm_rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/rsm_cfg_if.sv]
// Configuration write channel interface.
interface rsm_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [7:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[src/rs485_register_access_master_core.sv]
// Top level of the RS485 register access master core.
//
//  channel | dir | beat carries
//  req     | in  | action, address, command, register, payload, timeout, rx byte
//  rsp     | out | transmit byte with frame end, or status with outcome and data
//  cfg     | in  | register index and write data, always ready
//
// A received byte or a tick is taken every cycle while the output stage is free.
// A start request yields 4 to 6 transmit beats; the next item is taken in the
// cycle the last of them leaves.
// Status results are a single beat. rsp stalls hold the output stage, and req
// waits on it. Reset clears config registers to zero and returns to idle.
module rs485_register_access_master_core import rsm_pkg::*; (
	input logic clk,
	input logic arst_n,
	rsm_req_if.sink   req,
	rsm_rsp_if.source rsp,
	rsm_cfg_if.sink   cfg
);

	logic        in_fire;
	logic        has_result;
	logic        can_load;
	rsm_bundle_t bundle;

	assign cfg.ready = 1'b1;
	assign req.ready = can_load;
	assign in_fire   = req.valid && req.ready;

	rsm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.in_fire    (in_fire),
		.item       (req.data),
		.has_result (has_result),
		.bundle     (bundle)
	);

	rsm_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_fire && has_result),
		.bundle    (bundle),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.out_data  (rsp.data),
		.can_load  (can_load)
	);

endmodule

[src/rsm_ctrl.sv]
// Transaction control: config registers, frame build, reply tracking, timeout.
`include "rs485_register_access_master_core_macros.svh"
module rsm_ctrl import rsm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_fire,
	input  rsm_req_t    item,
	output logic        has_result,
	output rsm_bundle_t bundle
);

	logic [7:0]  start_marker_q, seed_q, read8_q, read16_q;
	logic [3:0]  ack_q, nack_q;
	logic        awaiting_q, awaiting_nxt;
	logic [2:0]  reply_len_q, reply_len_nxt;
	logic [2:0]  rcvd_q, rcvd_nxt;
	logic [7:0]  xor_q, xor_nxt;
	logic [15:0] ms_q, ms_nxt;
	logic [7:0]  reply_q [3];

	logic [1:0]  cnt;
	logic [7:0]  cmd_byte, csum, b, b0, b1, b2;
	logic [2:0]  rcvd_inc;
	logic        done, byte_we;
	logic [2:0]  outc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= '0;
			seed_q         <= '0;
			ack_q          <= '0;
			nack_q         <= '0;
			read8_q        <= '0;
			read16_q       <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START_MARKER:  start_marker_q <= cfg_data;
				CFG_CHECKSUM_SEED: seed_q <= cfg_data;
				CFG_ACK_NIBBLE:    ack_q <= cfg_data[3:0];
				CFG_NACK_NIBBLE:   nack_q <= cfg_data[3:0];
				CFG_READ8_CMD:     read8_q <= cfg_data;
				CFG_READ16_CMD:    read16_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign b        = item.incoming_byte;
	assign rcvd_inc = rcvd_q + 3'd1;
	assign done     = rcvd_inc >= reply_len_q;
	// the byte arriving now may be one that the status needs
	assign b0 = (rcvd_q[1:0] == 2'd0) ? b : reply_q[0];
	assign b1 = (rcvd_q[1:0] == 2'd1) ? b : reply_q[1];
	assign b2 = (rcvd_q[1:0] == 2'd2) ? b : reply_q[2];

	assign cnt      = (item.payload_count == 2'd3) ? 2'd2 : item.payload_count;
	assign cmd_byte = item.command_code | item.register_index;
	assign csum     = start_marker_q ^ item.device_address ^ cmd_byte
		^ ((cnt != 2'd0) ? item.payload_low : 8'h00)
		^ ((cnt == 2'd2) ? item.payload_high : 8'h00) ^ seed_q;

	always_comb begin
		priority if (b0[7:4] == nack_q) begin
			outc = OUTC_NACK;
		end else if (b0[7:4] == ack_q) begin
			outc = (reply_len_q > REPLY_SHORT && (xor_q ^ seed_q) != b)
				? OUTC_CHECKSUM : OUTC_OK;
		end else begin
			outc = OUTC_INVALID;
		end
	end

	always_comb begin
		has_result    = 1'b0;
		bundle        = '0;
		byte_we       = 1'b0;
		awaiting_nxt  = awaiting_q;
		reply_len_nxt = reply_len_q;
		rcvd_nxt      = rcvd_q;
		xor_nxt       = xor_q;
		ms_nxt        = ms_q;
		unique case (item.action)
			ACT_START: begin
				has_result      = 1'b1;
				bundle.kind     = KIND_TX;
				bundle.beats    = 3'd4 + {1'b0, cnt};
				bundle.bytes[0] = start_marker_q;
				bundle.bytes[1] = item.device_address;
				bundle.bytes[2] = cmd_byte;
				bundle.bytes[3] = (cnt == 2'd0) ? csum : item.payload_low;
				bundle.bytes[4] = (cnt == 2'd1) ? csum : item.payload_high;
				bundle.bytes[5] = csum;
				priority if (cnt != 2'd0)
					reply_len_nxt = REPLY_SHORT;
				else if (item.command_code == read8_q)
					reply_len_nxt = REPLY_READ8;
				else if (item.command_code == read16_q)
					reply_len_nxt = REPLY_READ16;
				else
					reply_len_nxt = REPLY_SHORT;
				awaiting_nxt = 1'b1;
				rcvd_nxt     = '0;
				xor_nxt      = '0;
				ms_nxt       = item.wait_limit_ms;
			end
			ACT_BYTE: begin
				if (awaiting_q) begin
					byte_we  = rcvd_q[1:0] != 2'd3;
					xor_nxt  = xor_q ^ b;
					rcvd_nxt = rcvd_inc;
					if (done) begin
						has_result     = 1'b1;
						bundle.kind    = KIND_STATUS;
						bundle.beats   = 3'd1;
						bundle.outcome = outc;
						if (outc == OUTC_OK && reply_len_q == REPLY_READ8)
							bundle.read_value = {8'h00, b1};
						else if (outc == OUTC_OK && reply_len_q == REPLY_READ16)
							bundle.read_value = {b2, b1};
						awaiting_nxt = 1'b0;
						rcvd_nxt     = '0;
						xor_nxt      = '0;
						ms_nxt       = '0;
					end
				end
			end
			ACT_TICK: begin
				if (awaiting_q) begin
					if (ms_q > 16'd1) begin
						ms_nxt = ms_q - 16'd1;
					end else begin
						has_result     = 1'b1;
						bundle.kind    = KIND_STATUS;
						bundle.beats   = 3'd1;
						bundle.outcome = OUTC_TIMEOUT;
						awaiting_nxt   = 1'b0;
						rcvd_nxt       = '0;
						xor_nxt        = '0;
						ms_nxt         = '0;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q  <= 1'b0;
			reply_len_q <= '0;
			rcvd_q      <= '0;
			xor_q       <= '0;
			ms_q        <= '0;
		end else if (in_fire) begin
			awaiting_q  <= awaiting_nxt;
			reply_len_q <= reply_len_nxt;
			rcvd_q      <= rcvd_nxt;
			xor_q       <= xor_nxt;
			ms_q        <= ms_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && byte_we)
			reply_q[rcvd_q[1:0]] <= b;
	end

	`RSM_ASSERT_NOW(a_len_range, clk, arst_n, awaiting_q,
		reply_len_q >= REPLY_SHORT && reply_len_q <= REPLY_READ16)
	`RSM_ASSERT_NOW(a_rcvd_below_len, clk, arst_n, awaiting_q, rcvd_q < reply_len_q)
	`RSM_ASSERT_NEXT(a_status_goes_idle, clk, arst_n,
		in_fire && has_result && bundle.kind == KIND_STATUS, !awaiting_q && rcvd_q == 3'd0)

endmodule

[src/rsm_emit.sv]
// Output stage: holds one item's results and hands them out one beat at a time.
`include "rs485_register_access_master_core_macros.svh"
module rsm_emit import rsm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  rsm_bundle_t bundle,
	input  logic        out_ready,
	output logic        out_valid,
	output rsm_rsp_t    out_data,
	output logic        can_load
);

	logic [2:0]                beats_q;
	logic                      kind_q;
	logic [FRAME_MAX-1:0][7:0] bytes_q;
	logic [2:0]                outcome_q;
	logic [15:0]               value_q;
	logic                      fire;

	assign out_valid = beats_q != 3'd0;
	assign fire      = out_valid && out_ready;
	assign can_load  = !out_valid || (fire && beats_q == 3'd1);

	assign out_data.result_kind   = kind_q;
	assign out_data.transmit_byte = bytes_q[0];
	assign out_data.frame_end     = kind_q == KIND_TX && beats_q == 3'd1;
	assign out_data.outcome       = outcome_q;
	assign out_data.read_value    = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			beats_q <= '0;
		else if (load)
			beats_q <= bundle.beats;
		else if (fire)
			beats_q <= beats_q - 3'd1;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q    <= bundle.kind;
			bytes_q   <= bundle.bytes;
			outcome_q <= bundle.outcome;
			value_q   <= bundle.read_value;
		end else if (fire) begin
			// frame shifts down so the next byte sits at the front
			bytes_q <= {8'h00, bytes_q[FRAME_MAX-1:1]};
		end
	end

	`RSM_ASSERT_NOW(a_load_when_free, clk, arst_n, load, can_load)
	`RSM_ASSERT_NOW(a_status_single, clk, arst_n,
		out_valid && kind_q == KIND_STATUS, beats_q == 3'd1)
	`RSM_ASSERT_NEXT(a_load_shows, clk, arst_n, load, out_valid)

endmodule
